// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the radix converter.
// Uses the clk and arst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, off while arst_n is low.
`define RC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("radix converter assertion failed");

// Same check with a message of the caller's choice.
`define RC_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

// ----- hw/rtl/rc_pkg.sv -----
// Package of the radix converter: status codes, register defaults,
// digit decode and glyph helpers. Depends on nothing.
package rc_pkg;

	localparam int VALUE_BITS_DEF = 64;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_DIGIT = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	localparam logic [4:0] SRC_BASE_RST = 5'd10;
	localparam logic [4:0] TGT_BASE_RST = 5'd2;
	localparam logic [4:0] BASE_MIN     = 5'd2;
	localparam logic [4:0] BASE_MAX     = 5'd16;
	localparam logic [4:0] NO_DIGIT     = 5'd16;

	localparam logic [7:0] GLYPHS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	function automatic logic [4:0] clamp_base(input logic [4:0] b);
		logic [4:0] r;
		if (b < BASE_MIN) r = BASE_MIN;
		else if (b > BASE_MAX) r = BASE_MAX;
		else r = b;
		return r;
	endfunction

	// Digit value 0..15, or NO_DIGIT for anything that is not a hex digit.
	function automatic logic [4:0] char_value(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
		else r = NO_DIGIT;
		return r;
	endfunction

endpackage

// ----- hw/rtl/radix_converter.sv -----
// Radix converter top level: APB register port, digit stream in, digit stream out.
// Depends on rc_pkg and assert_macros.svh.
//
// Usage:
//   s_* channel: one ASCII source digit per item in s_tdata, s_tlast on the last
//   character of a number. m_* channel: uppercase ASCII target digits, most
//   significant first, m_tuser carries the status, m_tlast ends the number.
//   An invalid digit or an overflow gives a single item with m_tdata 0 and the
//   first error code in m_tuser.
//   Registers: source_base at 0x0, target_base at 0x4, write only while idle.
// Operation:
//   One shared adder does the multiply, digit add and trial subtract. A character
//   goes through accept, 5 shift-add steps of the multiply by the source base, and
//   one add-and-check. An invalid character, or one after an error, is only accepted.
//   On the last character each target digit comes from bit-serial division of the
//   value, then every digit out goes through a store read and an output, plus any
//   stall. s_tready is low while an item is in work or results are pending.
// Reset: registers return to base 10 in, base 2 out, value and error cleared.
// Stall: a held m_tready holds the current result; nothing is dropped.
module radix_converter #(
	parameter int VALUE_BITS = rc_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] digit_in
	input  logic        s_tlast,   // final_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] digit_out
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // end_of_number
);

`include "assert_macros.svh"

	localparam int W  = VALUE_BITS + 5;
	localparam int SW = $clog2(VALUE_BITS);
	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam int AW = $clog2(VALUE_BITS);
	localparam int DEPTH = VALUE_BITS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_ADD  = 6'b000100,
		S_DIV  = 6'b001000,
		S_RD   = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [4:0]            src_q, tgt_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [1:0]            err_q;
	logic [CW-1:0]         count_q;
	logic [SW-1:0]         cnt_q;
	logic                  last_q;
	logic                  out_err_q;
	logic [W-1:0]          prod_q, mcand_q;
	logic [4:0]            mplier_q;
	logic [3:0]            dval_q;
	logic [4:0]            tbase_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [3:0]            rem_q;
	logic [3:0]            rdata_q;
	logic [3:0]            store [DEPTH];

	logic                  in_acc, out_acc, cfg_wr;
	logic [4:0]            in_base, in_d;
	logic [W-1:0]          add_a, add_b, add_sum;
	logic                  add_cin;
	logic [4:0]            div_r;
	logic                  div_neg;
	logic [3:0]            rem_nxt;
	logic [VALUE_BITS-1:0] v_nxt;
	logic                  mul_done, div_done, ovf;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);
	assign out_acc  = m_tvalid && m_tready;

	assign in_base = rc_pkg::clamp_base(src_q);
	assign in_d    = rc_pkg::char_value(s_tdata);

	always_comb begin
		case (paddr[2])
			1'b0:    prdata = {27'd0, src_q};
			default: prdata = {27'd0, tgt_q};
		endcase
	end

	// Shared adder: multiply steps, digit add, and division trial subtract.
	always_comb begin
		add_a   = prod_q;
		add_b   = '0;
		add_cin = 1'b0;
		case (state_q)
			S_MUL: begin
				add_b = mplier_q[0] ? mcand_q : '0;
			end
			S_ADD: begin
				add_b = {{(W-4){1'b0}}, dval_q};
			end
			S_DIV: begin
				add_a   = {{(W-5){1'b0}}, div_r};
				add_b   = ~{{(W-5){1'b0}}, tbase_q};
				add_cin = 1'b1;
			end
			default: begin
				add_b = '0;
			end
		endcase
	end
	assign add_sum = add_a + add_b + {{(W-1){1'b0}}, add_cin};

	assign div_r    = {rem_q, v_q[VALUE_BITS-1]};
	assign div_neg  = add_sum[W-1];
	assign rem_nxt  = div_neg ? div_r[3:0] : add_sum[3:0];
	assign v_nxt    = {v_q[VALUE_BITS-2:0], ~div_neg};
	assign mul_done = (cnt_q == SW'(4));
	assign div_done = (cnt_q == SW'(VALUE_BITS - 1));
	assign ovf      = (add_sum[W-1:VALUE_BITS] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= rc_pkg::SRC_BASE_RST;
			tgt_q <= rc_pkg::TGT_BASE_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) tgt_q <= pwdata[4:0];
			else src_q <= pwdata[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			acc_q     <= '0;
			err_q     <= rc_pkg::ST_OK;
			count_q   <= '0;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			out_err_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q <= s_tlast;
						if (err_q != rc_pkg::ST_OK || in_d >= in_base) begin
							if (err_q == rc_pkg::ST_OK) err_q <= rc_pkg::ST_BAD_DIGIT;
							if (s_tlast) begin
								out_err_q <= 1'b1;
								state_q   <= S_OUT;
							end
						end else begin
							cnt_q   <= '0;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + SW'(1);
					if (mul_done) state_q <= S_ADD;
				end
				S_ADD: begin
					cnt_q <= '0;
					if (ovf) begin
						err_q <= rc_pkg::ST_OVERFLOW;
					end else begin
						acc_q <= add_sum[VALUE_BITS-1:0];
					end
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (ovf) begin
						out_err_q <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						out_err_q <= 1'b0;
						count_q   <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cnt_q   <= '0;
						count_q <= count_q + CW'(1);
						if (v_nxt == '0) state_q <= S_RD;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
				S_RD: begin
					count_q <= count_q - CW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (m_tlast) begin
							acc_q     <= '0;
							err_q     <= rc_pkg::ST_OK;
							count_q   <= '0;
							out_err_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				prod_q   <= '0;
				mcand_q  <= {5'd0, acc_q};
				mplier_q <= in_base;
				dval_q   <= in_d[3:0];
			end
			S_MUL: begin
				prod_q   <= add_sum;
				mcand_q  <= {mcand_q[W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[4:1]};
			end
			S_ADD: begin
				v_q     <= add_sum[VALUE_BITS-1:0];
				rem_q   <= '0;
				tbase_q <= rc_pkg::clamp_base(tgt_q);
			end
			S_DIV: begin
				v_q   <= v_nxt;
				rem_q <= div_done ? 4'd0 : rem_nxt;
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	// Digit store: one write per finished division, one registered read.
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_done) store[count_q[AW-1:0]] <= rem_nxt;
		if (state_q == S_RD) rdata_q <= store[AW'(count_q - CW'(1))];
	end

	assign m_tdata = out_err_q ? 8'd0 : rc_pkg::GLYPHS[rdata_q];
	assign m_tuser = out_err_q ? err_q : rc_pkg::ST_OK;
	assign m_tlast = out_err_q || (count_q == '0);

	`RC_ASSERT(a_one_side, s_tready |-> !m_tvalid)
	`RC_ASSERT_MSG(a_err_item, (m_tvalid && m_tuser != rc_pkg::ST_OK) |-> (m_tlast && m_tdata == 8'd0),
		"error item must be a single zero digit")
	`RC_ASSERT_MSG(a_rem_range, (state_q == S_DIV) |-> (rem_q < tbase_q),
		"division remainder out of range")
	`RC_ASSERT(a_count_cap, count_q <= CW'(DEPTH))
	`RC_ASSERT(a_hold_out, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule
